FILE: rtl/ccle_pkg.sv
// Shared types, constants and CRC function of the camera command link engine.
`default_nettype none
package ccle_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_INFO_CODE  = 3'd1;
  localparam logic [2:0] REG_CTRL_CODE  = 3'd2;
  localparam logic [2:0] REG_START_MASK = 3'd3;
  localparam logic [2:0] REG_STOP_MASK  = 3'd4;

  // Input opcodes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RX    = 3'd1;
  localparam logic [2:0] OP_INFO  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;
  localparam logic [2:0] OP_RAW   = 3'd5;

  // Report status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CSUM    = 2'd2;
  localparam logic [1:0] ST_BUSY    = 2'd3;

  // Recording states
  localparam logic [1:0] REC_UNKNOWN   = 2'd0;
  localparam logic [1:0] REC_IDLE      = 2'd1;
  localparam logic [1:0] REC_RECORDING = 2'd2;

  // Protocol bytes
  localparam logic [7:0] HDR_BYTE  = 8'hCC;
  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] CRC_INIT  = 8'h00;
  localparam logic [7:0] ACT_START = 8'h05;
  localparam logic [7:0] ACT_STOP  = 8'h06;
  localparam logic [7:0] ACT_POWER = 8'h02;
  localparam logic [2:0] LEN_INFO  = 3'd5;
  localparam logic [2:0] LEN_CTRL  = 3'd2;

  // Configuration reset values
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
  localparam logic [7:0]  INFO_CODE_RST  = 8'd0;
  localparam logic [7:0]  CTRL_CODE_RST  = 8'd1;
  localparam logic [15:0] START_MASK_RST = 16'd64;
  localparam logic [15:0] STOP_MASK_RST  = 16'd128;

  // Link phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WAIT = 2'b10
  } phase_t;

  // One CRC-8 byte update, MSB first
  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the header byte, and after header and command byte at reset codes
  localparam logic [7:0] CRC_HDR      = crc8(CRC_INIT, HDR_BYTE);
  localparam logic [7:0] CRC_INFO_RST = crc8(CRC_HDR, INFO_CODE_RST);
  localparam logic [7:0] CRC_CTRL_RST = crc8(CRC_HDR, CTRL_CODE_RST);

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  info_code;
    logic [7:0]  ctrl_code;
    logic [15:0] start_mask;
    logic [15:0] stop_mask;
    logic [7:0]  crc_info;   // CRC over header and info command byte
    logic [7:0]  crc_ctrl;   // CRC over header and control command byte
  } cfg_t;

  // All results caused by one item
  typedef struct packed {
    logic [1:0]       n_m1;      // number of results minus one
    logic             report;
    logic [1:0]       status;
    logic [3:0][7:0]  bytes;
    logic [7:0]       version;
    logic [15:0]      features;
    logic [1:0]       rec;
    logic             info;
  } set_t;

endpackage
`default_nettype wire

FILE: rtl/ccle_if.sv
// Item and result stream interfaces of the camera command link engine.
`default_nettype none
interface ccle_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] rx_byte;
  logic [7:0] action;
  modport source (output valid, opcode, rx_byte, action, input ready);
  modport sink (input valid, opcode, rx_byte, action, output ready);
endinterface

interface ccle_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [7:0]  link_version;
  logic [15:0] features;
  logic [1:0]  recording_state;
  logic        info_valid;
  modport source (output valid, kind, tx_byte, last, status, link_version, features,
                  recording_state, info_valid, input ready);
  modport sink (input valid, kind, tx_byte, last, status, link_version, features,
                recording_state, info_valid, output ready);
endinterface
`default_nettype wire

FILE: rtl/ccle_cfg.sv
// Configuration register file with APB-style access.
`default_nettype none
module ccle_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ccle_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ccle_pkg::DATA_W-1:0]  pwdata,
  output logic      [ccle_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output ccle_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Write registers; keep command-byte CRCs in step with the codes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= ccle_pkg::TIMEOUT_RST;
      cfg.info_code     <= ccle_pkg::INFO_CODE_RST;
      cfg.ctrl_code     <= ccle_pkg::CTRL_CODE_RST;
      cfg.start_mask    <= ccle_pkg::START_MASK_RST;
      cfg.stop_mask     <= ccle_pkg::STOP_MASK_RST;
      cfg.crc_info      <= ccle_pkg::CRC_INFO_RST;
      cfg.crc_ctrl      <= ccle_pkg::CRC_CTRL_RST;
    end else if (wr_en) begin
      case (idx)
        ccle_pkg::REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
        ccle_pkg::REG_INFO_CODE: begin
          cfg.info_code <= pwdata[7:0];
          cfg.crc_info  <= ccle_pkg::crc8(ccle_pkg::CRC_HDR, pwdata[7:0]);
        end
        ccle_pkg::REG_CTRL_CODE: begin
          cfg.ctrl_code <= pwdata[7:0];
          cfg.crc_ctrl  <= ccle_pkg::crc8(ccle_pkg::CRC_HDR, pwdata[7:0]);
        end
        ccle_pkg::REG_START_MASK: cfg.start_mask <= pwdata[15:0];
        ccle_pkg::REG_STOP_MASK:  cfg.stop_mask  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      ccle_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ticks};
      ccle_pkg::REG_INFO_CODE:  prdata = {24'd0, cfg.info_code};
      ccle_pkg::REG_CTRL_CODE:  prdata = {24'd0, cfg.ctrl_code};
      ccle_pkg::REG_START_MASK: prdata = {16'd0, cfg.start_mask};
      ccle_pkg::REG_STOP_MASK:  prdata = {16'd0, cfg.stop_mask};
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ccle_core.sv
// Link state, frame build and response check: one item per cycle while the result register is free.
`default_nettype none
module ccle_core #(
  parameter int RESPONSE_MAX = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ccle_pkg::cfg_t  cfg,
  ccle_item_if.sink            item,
  input  wire logic            set_free,
  output logic                 set_valid,
  output ccle_pkg::set_t       set,
  output logic                 waiting
);

  localparam int IDX_W = (RESPONSE_MAX > 1) ? $clog2(RESPONSE_MAX) : 1;
  localparam int CNT_W = 3;

  ccle_pkg::phase_t  phase, phase_next;
  logic [2:0]        pending, pending_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [7:0]        crc, crc_next;
  logic [15:0]       wc, wc_next;
  logic [15:0]       feat, feat_next;
  logic [7:0]        ver, ver_next;
  logic              info, info_next;
  logic [1:0]        rec, rec_next;
  logic [7:0]        store [RESPONSE_MAX];
  logic              store_we;

  logic              accept;
  logic              is_wait;
  logic [15:0]       wc_inc;
  logic [15:0]       limit;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        crc_rx;
  logic [2:0]        expect_len;
  logic [7:0]        act_sel;
  logic [1:0]        rec_ok;

  assign item.ready = set_free;
  assign accept     = item.valid && set_free;
  assign is_wait    = (phase == ccle_pkg::PH_WAIT);
  assign waiting    = is_wait;
  assign wc_inc     = wc + 16'd1;
  assign limit      = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign cnt_inc    = cnt + CNT_W'(1);
  assign crc_rx     = ccle_pkg::crc8(crc, item.rx_byte);
  assign expect_len = (pending == ccle_pkg::OP_INFO) ? ccle_pkg::LEN_INFO
                                                     : ccle_pkg::LEN_CTRL;

  // Recording state after a successful control command
  always_comb begin
    case (pending)
      ccle_pkg::OP_START: rec_ok = ccle_pkg::REC_RECORDING;
      ccle_pkg::OP_STOP:  rec_ok = ccle_pkg::REC_IDLE;
      default:            rec_ok = rec;
    endcase
  end

  // Action byte of a control frame
  always_comb begin
    case (item.opcode)
      ccle_pkg::OP_START: act_sel = |(feat & cfg.start_mask) ? ccle_pkg::ACT_START
                                                             : ccle_pkg::ACT_POWER;
      ccle_pkg::OP_STOP:  act_sel = |(feat & cfg.stop_mask) ? ccle_pkg::ACT_STOP
                                                            : ccle_pkg::ACT_POWER;
      default:            act_sel = item.action;
    endcase
  end

  // Next state and result set of the item on the channel
  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    cnt_next     = cnt;
    crc_next     = crc;
    wc_next      = wc;
    feat_next    = feat;
    ver_next     = ver;
    info_next    = info;
    rec_next     = rec;
    store_we     = 1'b0;
    set_valid    = 1'b0;
    set.n_m1     = 2'd0;
    set.report   = 1'b1;
    set.status   = ccle_pkg::ST_OK;
    set.bytes    = '0;

    if (accept) begin
      case (item.opcode)
        ccle_pkg::OP_TICK: begin
          if (is_wait) begin
            wc_next = wc_inc;
            if (wc_inc >= limit) begin
              set_valid  = 1'b1;
              phase_next = ccle_pkg::PH_IDLE;
              cnt_next   = '0;
              crc_next   = ccle_pkg::CRC_INIT;
              wc_next    = '0;
              if (pending == ccle_pkg::OP_INFO) begin
                set.status = ccle_pkg::ST_TIMEOUT;
              end else begin
                rec_next = rec_ok;
              end
            end
          end
        end
        ccle_pkg::OP_RX: begin
          if (is_wait && !(cnt == '0 && item.rx_byte != ccle_pkg::HDR_BYTE)) begin
            store_we = 32'(cnt) < RESPONSE_MAX;
            cnt_next = cnt_inc;
            crc_next = crc_rx;
            if (cnt_inc == expect_len) begin
              set_valid  = 1'b1;
              phase_next = ccle_pkg::PH_IDLE;
              cnt_next   = '0;
              crc_next   = ccle_pkg::CRC_INIT;
              wc_next    = '0;
              if (crc_rx != 8'd0) begin
                set.status = ccle_pkg::ST_CSUM;
              end else if (pending == ccle_pkg::OP_INFO) begin
                ver_next  = store[1];
                feat_next = {store[3], store[2]};
                info_next = 1'b1;
              end else begin
                rec_next = rec_ok;
              end
            end
          end
        end
        ccle_pkg::OP_INFO, ccle_pkg::OP_START, ccle_pkg::OP_STOP, ccle_pkg::OP_RAW: begin
          set_valid = 1'b1;
          if (is_wait) begin
            set.status = ccle_pkg::ST_BUSY;
          end else begin
            // Build the frame; the header and command CRC come precomputed
            set.report   = 1'b0;
            set.bytes[0] = ccle_pkg::HDR_BYTE;
            if (item.opcode == ccle_pkg::OP_INFO) begin
              set.n_m1     = 2'd2;
              set.bytes[1] = cfg.info_code;
              set.bytes[2] = cfg.crc_info;
            end else begin
              set.n_m1     = 2'd3;
              set.bytes[1] = cfg.ctrl_code;
              set.bytes[2] = act_sel;
              set.bytes[3] = ccle_pkg::crc8(cfg.crc_ctrl, act_sel);
            end
            pending_next = item.opcode;
            phase_next   = ccle_pkg::PH_WAIT;
            cnt_next     = '0;
            crc_next     = ccle_pkg::CRC_INIT;
            wc_next      = '0;
          end
        end
        default: ;
      endcase
    end

    set.version  = ver_next;
    set.features = feat_next;
    set.rec      = rec_next;
    set.info     = info_next;
  end

  // Hold link state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ccle_pkg::PH_IDLE;
      pending <= '0;
      cnt     <= '0;
      crc     <= ccle_pkg::CRC_INIT;
      wc      <= '0;
      feat    <= '0;
      ver     <= '0;
      info    <= 1'b0;
      rec     <= ccle_pkg::REC_UNKNOWN;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
      cnt     <= cnt_next;
      crc     <= crc_next;
      wc      <= wc_next;
      feat    <= feat_next;
      ver     <= ver_next;
      info    <= info_next;
      rec     <= rec_next;
    end
  end

  // Response store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[IDX_W'(cnt)] <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ccle_outbuf.sv
// Result register: holds one result set and hands it out one transfer at a time.
`default_nettype none
module ccle_outbuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            set_valid,
  input  wire ccle_pkg::set_t  set,
  output logic                 set_free,
  ccle_result_if.source        result
);

  ccle_pkg::set_t held;
  logic           busy;
  logic [1:0]     idx;
  logic           at_end;
  logic           xfer;

  assign at_end   = (idx == held.n_m1);
  assign xfer     = busy && result.ready;
  assign set_free = !busy || (xfer && at_end);

  // Load a new set, advance through it, drop it after its final transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (set_free && set_valid) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (at_end) busy <= 1'b0;
      else        idx  <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (set_free && set_valid) begin
      held <= set;
    end
  end

  assign result.valid           = busy;
  assign result.kind            = held.report;
  assign result.tx_byte         = held.report ? 8'd0 : held.bytes[idx];
  assign result.last            = !held.report && at_end;
  assign result.status          = held.report ? held.status : ccle_pkg::ST_OK;
  assign result.link_version    = held.version;
  assign result.features        = held.features;
  assign result.recording_state = held.rec;
  assign result.info_valid      = held.info;

endmodule
`default_nettype wire

FILE: rtl/camera_command_link_engine_unit.sv
// Top level of the camera command link engine.
// The first result of an item is offered in the cycle after the item transfer.
// Throughput: one item per cycle while each item gives at most one result and the
// receiver is ready; a command frame holds the result register for its 3 or 4 bytes.
// Reset (rst, synchronous): link idle, stored info cleared, registers at defaults.
`default_nettype none
module camera_command_link_engine_unit #(
  parameter int RESPONSE_MAX = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ccle_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ccle_pkg::DATA_W-1:0]  pwdata,
  output logic      [ccle_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  ccle_item_if.sink                         item,
  ccle_result_if.source                     result
);

  ccle_pkg::cfg_t cfg;
  ccle_pkg::set_t set;
  logic           set_valid;
  logic           set_free;
  logic           waiting;
  logic           cmd_xfer;

  ccle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccle_core #(.RESPONSE_MAX(RESPONSE_MAX)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .set_free  (set_free),
    .set_valid (set_valid),
    .set       (set),
    .waiting   (waiting)
  );

  ccle_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set       (set),
    .set_free  (set_free),
    .result    (result)
  );

  assign cmd_xfer = item.valid && item.ready &&
                    (item.opcode == ccle_pkg::OP_INFO || item.opcode == ccle_pkg::OP_START ||
                     item.opcode == ccle_pkg::OP_STOP || item.opcode == ccle_pkg::OP_RAW);

  // A command in idle starts a frame with the header byte
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && !waiting |=> result.valid && !result.kind &&
                             result.tx_byte == ccle_pkg::HDR_BYTE)
    else $error("command in idle did not start a frame");

  // A command while waiting is rejected as busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && waiting |=> result.valid && result.kind &&
                            result.status == ccle_pkg::ST_BUSY)
    else $error("command while waiting not rejected");

  // The final frame byte leaves while the link waits for the response
  a_last_wait: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.kind && result.last |-> waiting)
    else $error("frame end seen outside the waiting phase");

endmodule
`default_nettype wire

FILE: dv/ccle_link_tb_pkg.sv
// Shared result type, spare opcodes and CRC helper for the link engine testbench.
`timescale 1ns / 100ps
package ccle_link_tb_pkg;
  import ccle_pkg::*;

  // Opcodes the engine has no use for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // One result item as seen on the result channel
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  version;
    logic [15:0] features;
    logic [1:0]  rec_state;
    logic        info_valid;
  } link_result_t;

  // Fold one byte into a CRC-8, most significant bit first
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = (r << 1) ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

endpackage

FILE: dv/ccle_link_checker.sv
// Checker that predicts the link engine's results and compares them with the result channel.
`timescale 1ns / 100ps
module ccle_link_checker
  import ccle_pkg::*;
  import ccle_link_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  ccle_item_if              item,
  ccle_result_if            result,
  output int                mismatches,
  output int                outstanding
);

  localparam int STORE_DEPTH = 5;

  // Shadow configuration
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_info_code;
  logic [7:0]  cfg_ctrl_code;
  logic [15:0] cfg_start_mask;
  logic [15:0] cfg_stop_mask;

  // Shadow link state
  phase_t      link_phase;
  logic [2:0]  pend_op;
  logic [7:0]  rsp_buf [STORE_DEPTH];
  logic [2:0]  rsp_cnt;
  logic [7:0]  rsp_crc;
  logic [15:0] tick_cnt;
  logic [15:0] feat;
  logic [7:0]  ver;
  logic        info_ok;
  logic [1:0]  rec;

  link_result_t expected_link_results[$];
  int           fails;

  // Queue one result carrying the stored info as it stands now
  task automatic queue_result(input logic kind, input logic [7:0] tx, input logic last,
                              input logic [1:0] status);
    link_result_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.last       = last;
    r.status     = status;
    r.version    = ver;
    r.features   = feat;
    r.rec_state  = rec;
    r.info_valid = info_ok;
    expected_link_results.push_back(r);
  endtask

  // Apply the recording state change of a successful control command
  task automatic mark_control_done();
    if (pend_op == OP_START) rec = REC_RECORDING;
    else if (pend_op == OP_STOP) rec = REC_IDLE;
  endtask

  // Return the link to idle
  task automatic end_wait();
    link_phase = PH_IDLE;
    rsp_cnt    = '0;
    rsp_crc    = CRC_INIT;
    tick_cnt   = '0;
  endtask

  // Work out the results of one accepted item and advance the shadow state
  task automatic predict_link_item(input logic [2:0] op, input logic [7:0] rx,
                                   input logic [7:0] act);
    logic [15:0] limit;
    logic [2:0]  need;
    logic [7:0]  frame [4];
    logic [7:0]  c;
    int          len;
    case (op)
      OP_TICK: begin
        if (link_phase == PH_WAIT) begin
          limit    = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= limit) begin
            if (pend_op == OP_INFO) begin
              end_wait();
              queue_result(1'b1, 8'h00, 1'b0, ST_TIMEOUT);
            end else begin
              // a control command that times out still counts as done
              mark_control_done();
              end_wait();
              queue_result(1'b1, 8'h00, 1'b0, ST_OK);
            end
          end
        end
      end
      OP_RX: begin
        // drop bytes until the header, and everything while idle
        if (link_phase == PH_WAIT && !(rsp_cnt == 3'd0 && rx != HDR_BYTE)) begin
          if (rsp_cnt < STORE_DEPTH) rsp_buf[rsp_cnt] = rx;
          rsp_cnt = rsp_cnt + 3'd1;
          rsp_crc = crc8_fold(rsp_crc, rx);
          need    = (pend_op == OP_INFO) ? LEN_INFO : LEN_CTRL;
          if (rsp_cnt >= need) begin
            if (rsp_crc != 8'h00) begin
              end_wait();
              queue_result(1'b1, 8'h00, 1'b0, ST_CSUM);
            end else begin
              if (pend_op == OP_INFO) begin
                ver     = rsp_buf[1];
                feat    = {rsp_buf[3], rsp_buf[2]};
                info_ok = 1'b1;
              end else begin
                mark_control_done();
              end
              end_wait();
              queue_result(1'b1, 8'h00, 1'b0, ST_OK);
            end
          end
        end
      end
      OP_INFO, OP_START, OP_STOP, OP_RAW: begin
        if (link_phase == PH_WAIT) begin
          // reject the command, the pending wait carries on
          queue_result(1'b1, 8'h00, 1'b0, ST_BUSY);
        end else begin
          frame[0] = HDR_BYTE;
          if (op == OP_INFO) begin
            frame[1] = cfg_info_code;
            len      = 3;
          end else begin
            frame[1] = cfg_ctrl_code;
            if (op == OP_START) frame[2] = |(feat & cfg_start_mask) ? ACT_START : ACT_POWER;
            else if (op == OP_STOP) frame[2] = |(feat & cfg_stop_mask) ? ACT_STOP : ACT_POWER;
            else frame[2] = act;
            len = 4;
          end
          c = CRC_INIT;
          for (int i = 0; i < len - 1; i++) c = crc8_fold(c, frame[i]);
          frame[len-1] = c;
          pend_op    = op;
          link_phase = PH_WAIT;
          rsp_cnt    = '0;
          rsp_crc    = CRC_INIT;
          tick_cnt   = '0;
          for (int i = 0; i < len; i++) queue_result(1'b0, frame[i], i == len - 1, ST_OK);
        end
      end
      default: ;
    endcase
  endtask

  // Compare result transfers, predict item transfers, track register writes
  always @(posedge clk) begin
    link_result_t got, want;
    if (rst) begin
      cfg_timeout    = TIMEOUT_RST;
      cfg_info_code  = INFO_CODE_RST;
      cfg_ctrl_code  = CTRL_CODE_RST;
      cfg_start_mask = START_MASK_RST;
      cfg_stop_mask  = STOP_MASK_RST;
      pend_op        = '0;
      feat           = '0;
      ver            = '0;
      info_ok        = 1'b0;
      rec            = REC_UNKNOWN;
      end_wait();
      expected_link_results.delete();
      fails = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.kind       = result.kind;
        got.tx_byte    = result.tx_byte;
        got.last       = result.last;
        got.status     = result.status;
        got.version    = result.link_version;
        got.features   = result.features;
        got.rec_state  = result.recording_state;
        got.info_valid = result.info_valid;
        if (expected_link_results.size() == 0) begin
          fails++;
          $display("%0t unexpected result: kind=%0d tx=%02h last=%0d status=%0d ver=%02h",
                   $time, got.kind, got.tx_byte, got.last, got.status, got.version,
                   " feat=%04h rec=%0d info=%0d", got.features, got.rec_state,
                   got.info_valid);
        end else begin
          want = expected_link_results.pop_front();
          if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
              got.last !== want.last || got.status !== want.status ||
              got.version !== want.version || got.features !== want.features ||
              got.rec_state !== want.rec_state || got.info_valid !== want.info_valid) begin
            fails++;
            $display("%0t mismatch expected: kind=%0d tx=%02h last=%0d status=%0d ver=%02h",
                     $time, want.kind, want.tx_byte, want.last, want.status, want.version,
                     " feat=%04h rec=%0d info=%0d", want.features, want.rec_state,
                     want.info_valid);
            $display("%0t mismatch actual:   kind=%0d tx=%02h last=%0d status=%0d ver=%02h",
                     $time, got.kind, got.tx_byte, got.last, got.status, got.version,
                     " feat=%04h rec=%0d info=%0d", got.features, got.rec_state,
                     got.info_valid);
          end
        end
      end
      if (item.valid && item.ready) predict_link_item(item.opcode, item.rx_byte, item.action);
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_TIMEOUT:    cfg_timeout    = pwdata[15:0];
          REG_INFO_CODE:  cfg_info_code  = pwdata[7:0];
          REG_CTRL_CODE:  cfg_ctrl_code  = pwdata[7:0];
          REG_START_MASK: cfg_start_mask = pwdata[15:0];
          REG_STOP_MASK:  cfg_stop_mask  = pwdata[15:0];
          default: ;
        endcase
      end
    end
    mismatches  <= fails;
    outstanding <= expected_link_results.size();
  end

endmodule

FILE: dv/tb_top.sv
// Top of the link engine testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import ccle_pkg::*;
  import ccle_link_tb_pkg::*;

  localparam int STALL_LIMIT = 500;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  int                items_sent = 0;
  int                burst_left = 0;
  int                quiet_cycles = 0;
  logic [15:0]       cur_timeout = TIMEOUT_RST;

  ccle_item_if   item ();
  ccle_result_if result ();

  camera_command_link_engine_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item),
    .result  (result)
  );

  ccle_link_checker chk (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .item        (item),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls: switch between stall patterns every so often
  initial begin
    int mode, left, step;
    mode = 0;
    left = 0;
    step = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end else begin
        left--;
      end
      step++;
      case (mode)
        0:       result.ready <= 1'b1;
        1:       result.ready <= 1'($urandom_range(0, 1));
        2:       result.ready <= (step % 4) == 0;
        default: result.ready <= (step % 12) < 2;
      endcase
    end
  end

  // End the run when nothing has been transferred for too long
  always @(posedge clk) begin
    if (rst || psel || (item.valid && item.ready) || (result.valid && result.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, in bursts with random gaps, and hold it until the transfer
  task automatic send_item(input logic [2:0] op, input logic [7:0] rx, input logic [7:0] act);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.valid   <= 1'b1;
    item.opcode  <= op;
    item.rx_byte <= rx;
    item.action  <= act;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has come, then settle
  task automatic wait_link_quiet();
    item.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_TIMEOUT) cur_timeout = value[15:0];
  endtask

  task automatic set_link_config(input logic [15:0] timeout, input logic [7:0] info_code,
                                 input logic [7:0] ctrl_code, input logic [15:0] start_mask,
                                 input logic [15:0] stop_mask);
    reg_write(REG_TIMEOUT, {16'h0, timeout});
    reg_write(REG_INFO_CODE, {24'h0, info_code});
    reg_write(REG_CTRL_CODE, {24'h0, ctrl_code});
    reg_write(REG_START_MASK, {16'h0, start_mask});
    reg_write(REG_STOP_MASK, {16'h0, stop_mask});
  endtask

  // Build a well-formed response: header, payload for info, closing CRC
  function automatic logic [4:0][7:0] make_response(input bit is_info, input logic [7:0] ver,
                                                    input logic [15:0] feat);
    logic [4:0][7:0] rsp;
    logic [7:0]      c;
    int              len;
    rsp    = '0;
    rsp[0] = HDR_BYTE;
    rsp[1] = ver;
    rsp[2] = feat[7:0];
    rsp[3] = feat[15:8];
    len    = is_info ? LEN_INFO : LEN_CTRL;
    c      = CRC_INIT;
    for (int i = 0; i < len - 1; i++) c = crc8_fold(c, rsp[i]);
    rsp[len-1] = c;
    return rsp;
  endfunction

  // Send a response straight through, optionally with a broken CRC
  task automatic send_response(input bit is_info, input logic [7:0] ver,
                               input logic [15:0] feat, input bit corrupt);
    logic [4:0][7:0] rsp;
    int              len;
    rsp = make_response(is_info, ver, feat);
    len = is_info ? LEN_INFO : LEN_CTRL;
    if (corrupt) rsp[len-1] = rsp[len-1] ^ 8'h01;
    for (int i = 0; i < len; i++) send_item(OP_RX, rsp[i], 8'($urandom));
  endtask

  function automatic logic [15:0] pick_bits16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // One command and its answer: good, broken CRC or timed out, with noise mixed in
  task automatic run_exchange();
    logic [4:0][7:0] rsp;
    logic [2:0]      cmd;
    logic [7:0]      b;
    int              k, len, n_send, ticks, limit, outcome;
    bit              timing_out;
    k   = $urandom_range(0, 99);
    cmd = (k < 30) ? OP_INFO : (k < 50) ? OP_START : (k < 70) ? OP_STOP : OP_RAW;
    send_item(cmd, 8'($urandom), 8'($urandom));
    // bytes ahead of the header are dropped
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == HDR_BYTE) b = ~b;
      send_item(OP_RX, b, 8'($urandom));
    end
    limit      = (cur_timeout == 16'd0) ? 1 : int'(cur_timeout);
    len        = (cmd == OP_INFO) ? LEN_INFO : LEN_CTRL;
    rsp        = make_response(cmd == OP_INFO, 8'($urandom), pick_bits16());
    outcome    = $urandom_range(0, 99);
    timing_out = outcome < 15 && limit <= 40;
    ticks      = 0;
    if (timing_out) begin
      n_send = $urandom_range(0, len - 1);
    end else begin
      n_send = len;
      if (outcome < 32) rsp[len-1] = rsp[len-1] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < n_send; i++) begin
      if (ticks + 1 < limit && $urandom_range(0, 3) == 0) begin
        send_item(OP_TICK, 8'($urandom), 8'($urandom));
        ticks++;
      end
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom_range(OP_INFO, OP_RAW)), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 29) == 0)
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      send_item(OP_RX, rsp[i], 8'($urandom));
    end
    if (timing_out) begin
      while (ticks < limit) begin
        send_item(OP_TICK, 8'($urandom), 8'($urandom));
        ticks++;
      end
    end
    // occasional item that the idle link ignores
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       send_item(OP_TICK, 8'($urandom), 8'($urandom));
        1:       send_item(OP_RX, 8'($urandom), 8'($urandom));
        2:       send_item(OP_SPARE_6, 8'($urandom), 8'($urandom));
        default: send_item(OP_SPARE_7, 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic run_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) run_exchange();
    wait_link_quiet();
  endtask

  // Reset, directed checks, then random phases under several settings
  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    item.valid   <= 1'b0;
    item.opcode  <= OP_TICK;
    item.rx_byte <= 8'h00;
    item.action  <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle link ignores ticks, bytes and spare opcodes
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_RX, HDR_BYTE, 8'h00);
    send_item(OP_SPARE_6, 8'hFF, 8'hFF);
    send_item(OP_SPARE_7, 8'h00, 8'h00);
    // no features known yet: start and stop fall back to the power button
    send_item(OP_START, 8'h00, 8'h00);
    send_response(1'b0, 8'h00, 16'h0000, 1'b0);
    send_item(OP_STOP, 8'hFF, 8'hFF);
    send_item(OP_RX, 8'h00, 8'h00);
    send_response(1'b0, 8'h00, 16'h0000, 1'b1);
    // info query with a busy command and a dropped byte ahead of the header
    send_item(OP_INFO, 8'h00, 8'h00);
    send_item(OP_RAW, 8'h00, 8'h00);
    send_item(OP_RX, 8'hFF, 8'h00);
    send_response(1'b1, 8'hFF, 16'hFFFF, 1'b0);
    // features advertised: explicit start and stop
    send_item(OP_START, 8'h00, 8'h00);
    send_response(1'b0, 8'h00, 16'h0000, 1'b0);
    send_item(OP_STOP, 8'h00, 8'h00);
    send_response(1'b0, 8'h00, 16'h0000, 1'b0);
    send_item(OP_RAW, 8'h00, 8'hFF);
    send_response(1'b0, 8'h00, 16'h0000, 1'b0);
    wait_link_quiet();

    set_link_config(16'd1, 8'hFF, 8'h00, 16'hFFFF, 16'h0000);
    run_phase(50);
    set_link_config(16'd0, 8'($urandom), 8'($urandom), 16'h0000, 16'hFFFF);
    run_phase(50);
    set_link_config(16'hFFFF, 8'h00, 8'hFF, 16'h0001 << $urandom_range(0, 15),
                    16'h0001 << $urandom_range(0, 15));
    run_phase(45);
    set_link_config(16'($urandom_range(2, 12)), 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom));
    run_phase(50);
    set_link_config(16'd3, 8'($urandom), 8'($urandom), pick_bits16(), pick_bits16());
    run_phase(50);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
